// ===== rtl/csp_pkg.sv =====
// ----------------------------------------------------------------------------
// csp_pkg
// Types, constants and the letter decoder shared by the CIGAR string parser.
// ----------------------------------------------------------------------------
package csp_pkg;

	localparam int LENGTH_BITS_DEF = 32;
	localparam int RUN_BITS        = 32;
	localparam int OFFSET_BITS     = 32;

	localparam logic [3:0] OP_M = 4'd0;
	localparam logic [3:0] OP_I = 4'd1;
	localparam logic [3:0] OP_D = 4'd2;
	localparam logic [3:0] OP_N = 4'd3;
	localparam logic [3:0] OP_S = 4'd4;
	localparam logic [3:0] OP_H = 4'd5;
	localparam logic [3:0] OP_P = 4'd6;
	localparam logic [3:0] OP_T = 4'd7;
	localparam logic [3:0] OP_U = 4'd8;

	typedef enum logic [1:0] {
		ERR_NONE       = 2'd0,
		ERR_BAD_LETTER = 2'd1,
		ERR_NO_DIGITS  = 2'd2,
		ERR_MID_NUMBER = 2'd3
	} csp_err_t;

	typedef enum logic [1:0] {
		KIND_DIGIT,
		KIND_OP,
		KIND_BAD
	} csp_kind_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_string;
	} csp_in_t;

	typedef struct packed {
		logic [3:0]          op_code;
		logic [RUN_BITS-1:0] run_length;
		logic                last_unit;
		csp_err_t            error_code;
	} csp_out_t;

	typedef struct packed {
		csp_kind_t  kind;
		logic [3:0] value;
		logic       eos;
	} csp_item_t;

	typedef struct packed {
		logic      valid;
		csp_item_t item;
	} csp_fq_t;

	function automatic csp_item_t csp_classify(input csp_in_t c);
		csp_item_t r;
		r.eos   = c.end_of_string;
		r.kind  = KIND_OP;
		r.value = 4'd0;
		case (c.char_byte)
			"M": r.value = OP_M;
			"I": r.value = OP_I;
			"D": r.value = OP_D;
			"N": r.value = OP_N;
			"S": r.value = OP_S;
			"H": r.value = OP_H;
			"P": r.value = OP_P;
			"T": r.value = OP_T;
			"U": r.value = OP_U;
			default: begin
				if (c.char_byte >= "0" && c.char_byte <= "9") begin
					r.kind  = KIND_DIGIT;
					r.value = 4'(c.char_byte - 8'h30);
				end else begin
					r.kind = KIND_BAD;
				end
			end
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/cigar_string_parser_top.sv =====
// ----------------------------------------------------------------------------
// cigar_string_parser_top
// CIGAR string parser: characters in, merged operation units out.
// ----------------------------------------------------------------------------
// The parser takes one character per clock cycle. A character is classified
// on entry and parked in a two-entry queue; the execution stage then consumes
// one queued character per cycle and writes zero, one or two result units into
// a four-entry result queue. A character is taken from the input queue only
// when the result queue has room for two units, so the sustained input rate is
// one character per cycle for as long as results are popped at least as fast
// as they are produced. The leading offset register is sampled on the first
// character of each string.
// ----------------------------------------------------------------------------
module cigar_string_parser_top
	import csp_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  csp_in_t                item,
	output logic                   empty,
	input  logic                   pop,
	output csp_out_t               rslt,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [OFFSET_BITS-1:0] cfg_data
);

	csp_fq_t fq;
	logic    take;

	assign cfg_ready = 1'b1;

	csp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.fq     (fq),
		.take   (take)
	);

	csp_back #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.fq       (fq),
		.take     (take),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.empty    (empty),
		.pop      (pop),
		.rslt     (rslt)
	);

endmodule

// ===== rtl/csp_front.sv =====
// ----------------------------------------------------------------------------
// csp_front
// Accepts characters, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module csp_front
	import csp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  csp_in_t item,
	output csp_fq_t fq,
	input  logic    take
);

	csp_item_t  store_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push_fire;
	logic       pop_fire;

	assign full      = (cnt_q == 2'd2);
	assign push_fire = push && !full;
	assign pop_fire  = take && (cnt_q != 2'd0);

	assign fq.valid = (cnt_q != 2'd0);
	assign fq.item  = store_q[rd_q];

	always_ff @(posedge clk) begin
		if (push_fire) begin
			store_q[wr_q] <= csp_classify(item);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push_fire) begin
				wr_q <= !wr_q;
			end
			if (pop_fire) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push_fire) - 2'(pop_fire);
		end
	end

endmodule

// ===== rtl/csp_back.sv =====
// ----------------------------------------------------------------------------
// csp_back
// Runs the parse state on classified characters and queues the results.
// ----------------------------------------------------------------------------
module csp_back
	import csp_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  csp_fq_t                fq,
	output logic                   take,
	input  logic                   cfg_we,
	input  logic [OFFSET_BITS-1:0] cfg_data,
	output logic                   empty,
	input  logic                   pop,
	output csp_out_t               rslt
);

	localparam int MW = (LENGTH_BITS > OFFSET_BITS) ? LENGTH_BITS : OFFSET_BITS;
	localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

	logic [OFFSET_BITS-1:0] offset_q;
	logic [LENGTH_BITS-1:0] acc_q;
	logic                   have_digits_q;
	logic [3:0]             held_op_q;
	logic [LENGTH_BITS-1:0] held_len_q;
	logic                   held_valid_q;
	logic                   start_q;
	logic                   discard_q;

	logic [LENGTH_BITS-1:0] acc_n;
	logic                   have_digits_n;
	logic [3:0]             held_op_n;
	logic [LENGTH_BITS-1:0] held_len_n;
	logic                   held_valid_n;
	logic                   start_n;
	logic                   discard_n;

	logic [3:0]             eff_op;
	logic [LENGTH_BITS-1:0] eff_len;
	logic                   eff_valid;
	logic [OFFSET_BITS-1:0] mag;
	logic [MW-1:0]          mag_ext;
	logic [LENGTH_BITS-1:0] off_len;
	logic [LENGTH_BITS+3:0] acc_ten;
	logic [LENGTH_BITS-1:0] acc_next;
	logic [LENGTH_BITS:0]   merge_sum;
	logic [LENGTH_BITS-1:0] merge_len;

	csp_out_t   res0;
	csp_out_t   res1;
	logic [1:0] nres;

	csp_out_t   oq_q [4];
	logic [1:0] owr_q;
	logic [1:0] ord_q;
	logic [2:0] ocnt_q;
	logic       opop;
	logic       fire;

	assign take = fq.valid && (ocnt_q <= 3'd2);
	assign fire = take;

	assign mag       = offset_q[OFFSET_BITS-1] ? (~offset_q + 1'b1) : offset_q;
	assign mag_ext   = MW'(mag);
	assign off_len   = (MW'(LEN_MAX) < mag_ext) ? LEN_MAX : mag_ext[LENGTH_BITS-1:0];
	assign acc_ten   = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1)
	                   + (LENGTH_BITS+4)'(fq.item.value);
	assign acc_next  = (|acc_ten[LENGTH_BITS+3:LENGTH_BITS]) ? LEN_MAX
	                   : acc_ten[LENGTH_BITS-1:0];
	assign merge_sum = {1'b0, eff_len} + {1'b0, acc_q};
	assign merge_len = merge_sum[LENGTH_BITS] ? LEN_MAX : merge_sum[LENGTH_BITS-1:0];

	always_comb begin
		eff_op    = held_op_q;
		eff_len   = held_len_q;
		eff_valid = held_valid_q;
		if (start_q && offset_q != '0) begin
			eff_op    = offset_q[OFFSET_BITS-1] ? OP_I : OP_D;
			eff_len   = off_len;
			eff_valid = 1'b1;
		end
	end

	always_comb begin
		acc_n         = acc_q;
		have_digits_n = have_digits_q;
		held_op_n     = held_op_q;
		held_len_n    = held_len_q;
		held_valid_n  = held_valid_q;
		start_n       = start_q;
		discard_n     = discard_q;
		nres          = 2'd0;
		res0          = '{op_code: OP_M, run_length: '0, last_unit: 1'b1,
		                  error_code: ERR_NONE};
		res1          = res0;
		if (discard_q) begin
			if (fq.item.eos) begin
				discard_n = 1'b0;
				start_n   = 1'b1;
			end
		end else begin
			start_n      = 1'b0;
			held_op_n    = eff_op;
			held_len_n   = eff_len;
			held_valid_n = eff_valid;
			case (fq.item.kind)
				KIND_DIGIT: begin
					acc_n         = acc_next;
					have_digits_n = 1'b1;
					if (fq.item.eos) begin
						nres            = 2'd1;
						res0.error_code = ERR_MID_NUMBER;
					end
				end
				KIND_OP: begin
					if (!have_digits_q) begin
						nres            = 2'd1;
						res0.error_code = ERR_NO_DIGITS;
						discard_n       = !fq.item.eos;
					end else begin
						if (eff_valid && eff_op == fq.item.value) begin
							held_len_n = merge_len;
						end else begin
							if (eff_valid) begin
								res0.op_code    = eff_op;
								res0.run_length = RUN_BITS'(eff_len);
								res0.last_unit  = 1'b0;
								nres            = 2'd1;
							end
							held_op_n    = fq.item.value;
							held_len_n   = acc_q;
							held_valid_n = 1'b1;
						end
						acc_n         = '0;
						have_digits_n = 1'b0;
						if (fq.item.eos) begin
							if (nres == 2'd1) begin
								res1.op_code    = held_op_n;
								res1.run_length = RUN_BITS'(held_len_n);
								nres            = 2'd2;
							end else begin
								res0.op_code    = held_op_n;
								res0.run_length = RUN_BITS'(held_len_n);
								nres            = 2'd1;
							end
						end
					end
				end
				default: begin
					nres            = 2'd1;
					res0.error_code = ERR_BAD_LETTER;
					discard_n       = !fq.item.eos;
				end
			endcase
			if (nres != 2'd0 && (res0.last_unit || res1.last_unit) &&
			    (fq.item.eos || res0.error_code != ERR_NONE)) begin
				acc_n         = '0;
				have_digits_n = 1'b0;
				held_op_n     = OP_M;
				held_len_n    = '0;
				held_valid_n  = 1'b0;
				start_n       = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q      <= '0;
			acc_q         <= '0;
			have_digits_q <= 1'b0;
			held_op_q     <= OP_M;
			held_len_q    <= '0;
			held_valid_q  <= 1'b0;
			start_q       <= 1'b1;
			discard_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				offset_q <= cfg_data;
			end
			if (fire) begin
				acc_q         <= acc_n;
				have_digits_q <= have_digits_n;
				held_op_q     <= held_op_n;
				held_len_q    <= held_len_n;
				held_valid_q  <= held_valid_n;
				start_q       <= start_n;
				discard_q     <= discard_n;
			end
		end
	end

	assign empty = (ocnt_q == 3'd0);
	assign opop  = pop && !empty;
	assign rslt  = oq_q[ord_q];

	always_ff @(posedge clk) begin
		if (fire && nres != 2'd0) begin
			oq_q[owr_q] <= res0;
		end
		if (fire && nres == 2'd2) begin
			oq_q[owr_q + 2'd1] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= 2'd0;
			ord_q  <= 2'd0;
			ocnt_q <= 3'd0;
		end else begin
			if (fire) begin
				owr_q <= owr_q + nres;
			end
			if (opop) begin
				ord_q <= ord_q + 2'd1;
			end
			ocnt_q <= ocnt_q + (fire ? 3'(nres) : 3'd0) - 3'(opop);
		end
	end

endmodule

// ===== rtl/csp_checker.sv =====
// ----------------------------------------------------------------------------
// csp_checker
// Port-level checks for the CIGAR string parser, bound to the top level.
// ----------------------------------------------------------------------------
module csp_checker
	import csp_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   push,
	input logic                   full,
	input csp_in_t                item,
	input logic                   empty,
	input logic                   pop,
	input csp_out_t               rslt,
	input logic                   cfg_valid,
	input logic                   cfg_ready,
	input logic [OFFSET_BITS-1:0] cfg_data
);

	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rslt.error_code != ERR_NONE) |->
		(rslt.last_unit && rslt.run_length == '0 && rslt.op_code == OP_M))
		else $error("error transaction is not a bare final unit");

	a_op_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (rslt.op_code <= OP_U))
		else $error("op code out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(rslt)))
		else $error("waiting result changed before it was popped");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration transaction stalled");

endmodule

bind cigar_string_parser_top csp_checker u_csp_checker (.*);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the CIGAR string parser.
// ----------------------------------------------------------------------------
// Characters go in through the push/full queue port in bursts with random
// gaps, and merged units are popped under changing stall patterns. A
// behavioral parser in the bench predicts the units that a directed row does
// not list itself, and each popped unit is compared with the oldest
// prediction. A short table of directed characters covers the zero length,
// saturation, error and flush cases. Random strings follow under several
// leading offsets, mostly well formed, some broken and some pure noise.
// ----------------------------------------------------------------------------
module tb;
	import csp_pkg::*;

	localparam logic [63:0] LEN_MAX = {64{1'b1}} >> (64 - LENGTH_BITS_DEF);
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 12;
	localparam int PHASES = 7;
	localparam int PHASE_CHARS = 230;
	localparam int MAX_REPORTS = 40;
	localparam logic [7:0] OP_LETTER [9] = '{"M", "I", "D", "N", "S", "H", "P", "T", "U"};
	localparam csp_out_t NO_UNIT = '0;

	typedef enum int {
		FAULT_NONE,
		FAULT_BAD_CHAR,
		FAULT_NO_DIGITS,
		FAULT_OPEN_NUMBER
	} fault_t;

	typedef enum int {
		RX_FREE,
		RX_COIN,
		RX_SPARSE,
		RX_STALLS
	} rx_mode_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       eos;
		logic       typed;
		logic [1:0] n;
		csp_out_t   r0;
		csp_out_t   r1;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	csp_in_t item = '0;
	logic empty;
	logic pop = 1'b0;
	csp_out_t rslt;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [OFFSET_BITS-1:0] cfg_data = '0;

	cigar_string_parser_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.rslt(rslt),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Parser state kept by the bench.
	logic [31:0] offset_reg = '0;
	logic [63:0] acc_len = '0;
	logic        have_digits = 1'b0;
	logic [3:0]  hold_op = OP_M;
	logic [63:0] hold_len = '0;
	logic        hold_valid = 1'b0;
	logic        at_start = 1'b1;
	logic        skipping = 1'b0;

	csp_out_t expected_units [$];
	logic [7:0] cigar_text [$];
	stim_row_t directed_rows [$];

	logic       row_typed = 1'b0;
	logic [1:0] row_n = '0;
	csp_out_t   row_res [2];

	int chars_sent = 0;
	int units_checked = 0;
	int offset_writes = 0;
	int mismatches = 0;
	int burst_left = 0;
	int quiet_cycles = 0;
	rx_mode_t rx_mode = RX_FREE;
	int rx_left = 0;
	int rx_stall = 0;

	function automatic csp_out_t mk_unit(logic [3:0] op, logic [63:0] len, logic last,
			csp_err_t err);
		csp_out_t u;
		u.op_code = op;
		u.run_length = RUN_BITS'(len);
		u.last_unit = last;
		u.error_code = err;
		return u;
	endfunction

	function automatic int op_of(logic [7:0] ch);
		case (ch)
			"M": return OP_M;
			"I": return OP_I;
			"D": return OP_D;
			"N": return OP_N;
			"S": return OP_S;
			"H": return OP_H;
			"P": return OP_P;
			"T": return OP_T;
			"U": return OP_U;
			default: return -1;
		endcase
	endfunction

	function automatic void clear_parse();
		acc_len = '0;
		have_digits = 1'b0;
		hold_op = OP_M;
		hold_len = '0;
		hold_valid = 1'b0;
		at_start = 1'b1;
		skipping = 1'b0;
	endfunction

	function automatic csp_out_t parse_error(csp_err_t err, logic at_end);
		clear_parse();
		skipping = !at_end;
		return mk_unit(OP_M, '0, 1'b1, err);
	endfunction

	task automatic parse_cigar_char(input csp_in_t c, output csp_out_t res [2], output int n);
		logic [63:0] d;
		logic [31:0] neg;
		logic [63:0] sum;
		int op;
		n = 0;
		res[0] = NO_UNIT;
		res[1] = NO_UNIT;
		if (skipping) begin
			if (c.end_of_string)
				clear_parse();
			return;
		end
		if (at_start) begin
			at_start = 1'b0;
			if (offset_reg != 0) begin
				if (offset_reg[31]) begin
					neg = ~offset_reg + 32'd1;
					hold_len = {32'd0, neg};
					hold_op = OP_I;
				end else begin
					hold_len = {32'd0, offset_reg};
					hold_op = OP_D;
				end
				if (hold_len > LEN_MAX)
					hold_len = LEN_MAX;
				hold_valid = 1'b1;
			end
		end
		if (c.char_byte >= "0" && c.char_byte <= "9") begin
			d = 64'(c.char_byte - 8'h30);
			if (acc_len > (LEN_MAX - d) / 10)
				acc_len = LEN_MAX;
			else
				acc_len = acc_len * 10 + d;
			have_digits = 1'b1;
			if (c.end_of_string) begin
				res[0] = parse_error(ERR_MID_NUMBER, 1'b1);
				n = 1;
			end
			return;
		end
		op = op_of(c.char_byte);
		if (op < 0 || !have_digits) begin
			res[0] = parse_error((op < 0) ? ERR_BAD_LETTER : ERR_NO_DIGITS, c.end_of_string);
			n = 1;
			return;
		end
		if (hold_valid && hold_op == 4'(op)) begin
			sum = hold_len + acc_len;
			hold_len = (sum > LEN_MAX) ? LEN_MAX : sum;
		end else begin
			if (hold_valid) begin
				res[n] = mk_unit(hold_op, hold_len, 1'b0, ERR_NONE);
				n++;
			end
			hold_op = 4'(op);
			hold_len = acc_len;
			hold_valid = 1'b1;
		end
		acc_len = '0;
		have_digits = 1'b0;
		if (c.end_of_string) begin
			res[n] = mk_unit(hold_op, hold_len, 1'b1, ERR_NONE);
			n++;
			clear_parse();
		end
	endtask

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("tb: mismatch: %s", msg);
	endtask

	always @(posedge clk) begin : monitor
		csp_out_t got_units [2];
		int got_n;
		csp_out_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				offset_reg = cfg_data;
			if (push && !full) begin
				parse_cigar_char(item, got_units, got_n);
				if (row_typed) begin
					for (int k = 0; k < int'(row_n); k++)
						expected_units.insert(expected_units.size(), row_res[k]);
				end else begin
					for (int k = 0; k < got_n; k++)
						expected_units.insert(expected_units.size(), got_units[k]);
				end
			end
			if (pop && !empty) begin
				if (expected_units.size() == 0) begin
					report_mismatch($sformatf("unexpected unit: op %0d len %0d last %0b err %0d",
						rslt.op_code, rslt.run_length, rslt.last_unit, rslt.error_code));
				end else begin
					want = expected_units.pop_front();
					if (rslt !== want)
						report_mismatch($sformatf(
							"unit %0d: got %0d/%0d/%0b/%0d want %0d/%0d/%0b/%0d",
							units_checked, rslt.op_code, rslt.run_length, rslt.last_unit,
							rslt.error_code, want.op_code, want.run_length, want.last_unit,
							want.error_code));
				end
				units_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: watchdog expired with %0d units still expected",
					expected_units.size());
				$display("tb: FAIL");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(RX_FREE, RX_STALLS));
				rx_left = $urandom_range(50, 300);
			end
			rx_left--;
			case (rx_mode)
				RX_FREE: pop <= 1'b1;
				RX_COIN: pop <= 1'($urandom_range(0, 1));
				RX_SPARSE: pop <= (rx_left % 4 == 0);
				default: begin
					if (rx_stall > 0) begin
						rx_stall--;
						pop <= 1'b0;
					end else begin
						pop <= 1'b1;
						if ($urandom_range(0, 9) == 0)
							rx_stall = $urandom_range(5, 25);
					end
				end
			endcase
		end
	end

	task automatic send_char(input logic [7:0] ch, input logic eos, input logic typed,
			input logic [1:0] n, input csp_out_t r0, input csp_out_t r1);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				push <= 1'b0;
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		@(negedge clk);
		push <= 1'b1;
		item <= '{char_byte: ch, end_of_string: eos};
		row_typed <= typed;
		row_n <= n;
		row_res[0] <= r0;
		row_res[1] <= r1;
		do @(posedge clk); while (full);
		chars_sent++;
	endtask

	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		while (expected_units.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_offset(input logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		offset_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic void add_row(logic [7:0] ch, logic eos, logic typed, logic [1:0] n,
			csp_out_t r0, csp_out_t r1);
		directed_rows.insert(directed_rows.size(),
			'{ch: ch, eos: eos, typed: typed, n: n, r0: r0, r1: r1});
	endfunction

	function automatic void append_number();
		int r;
		int nd;
		r = $urandom_range(0, 19);
		if (r == 0) begin
			cigar_text.insert(cigar_text.size(), "0");
			return;
		end
		nd = (r == 1) ? $urandom_range(10, 11) : $urandom_range(1, 3);
		repeat (nd) cigar_text.insert(cigar_text.size(), 8'h30 + 8'($urandom_range(0, 9)));
	endfunction

	function automatic logic [7:0] stray_byte();
		logic [7:0] b;
		do
			b = 8'($urandom);
		while ((b >= "0" && b <= "9") || op_of(b) >= 0);
		return b;
	endfunction

	task automatic send_random_string();
		int roll;
		int nunits;
		int cut;
		int prev_op;
		int op;
		fault_t fault;
		cigar_text.delete();
		roll = $urandom_range(0, 99);
		if (roll >= 95) begin
			repeat ($urandom_range(1, 8)) cigar_text.insert(cigar_text.size(), 8'($urandom));
		end else begin
			nunits = $urandom_range(1, 6);
			fault = (roll < 80) ? FAULT_NONE
				: fault_t'($urandom_range(FAULT_BAD_CHAR, FAULT_OPEN_NUMBER));
			cut = $urandom_range(0, nunits - 1);
			prev_op = $urandom_range(0, 8);
			for (int u = 0; u < nunits; u++) begin
				if (u == cut && fault == FAULT_BAD_CHAR)
					cigar_text.insert(cigar_text.size(), stray_byte());
				if (u == cut && fault == FAULT_NO_DIGITS)
					cigar_text.insert(cigar_text.size(), OP_LETTER[$urandom_range(0, 8)]);
				op = ($urandom_range(0, 3) == 0) ? prev_op : $urandom_range(0, 8);
				append_number();
				cigar_text.insert(cigar_text.size(), OP_LETTER[op]);
				prev_op = op;
			end
			if (fault == FAULT_OPEN_NUMBER)
				append_number();
		end
		foreach (cigar_text[i])
			send_char(cigar_text[i], i == cigar_text.size() - 1, 1'b0, 2'd0, NO_UNIT, NO_UNIT);
	endtask

	initial begin : stimulus
		logic [31:0] offset_plan [PHASES];
		int phase_start;
		offset_plan = '{32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'($urandom_range(2, 99)), 32'($urandom), 32'd0};

		add_row("0", 1'b0, 1'b1, 2'd0, NO_UNIT, NO_UNIT);
		add_row("M", 1'b1, 1'b1, 2'd1, mk_unit(OP_M, 0, 1'b1, ERR_NONE), NO_UNIT);
		add_row("X", 1'b1, 1'b1, 2'd1, mk_unit(OP_M, 0, 1'b1, ERR_BAD_LETTER), NO_UNIT);
		add_row("M", 1'b1, 1'b1, 2'd1, mk_unit(OP_M, 0, 1'b1, ERR_NO_DIGITS), NO_UNIT);
		add_row("5", 1'b1, 1'b1, 2'd1, mk_unit(OP_M, 0, 1'b1, ERR_MID_NUMBER), NO_UNIT);
		add_row(8'h00, 1'b1, 1'b1, 2'd1, mk_unit(OP_M, 0, 1'b1, ERR_BAD_LETTER), NO_UNIT);
		repeat (10) add_row("9", 1'b0, 1'b0, 2'd0, NO_UNIT, NO_UNIT);
		add_row("U", 1'b1, 1'b1, 2'd1, mk_unit(OP_U, LEN_MAX, 1'b1, ERR_NONE), NO_UNIT);
		add_row("3", 1'b0, 1'b0, 2'd0, NO_UNIT, NO_UNIT);
		add_row("M", 1'b0, 1'b0, 2'd0, NO_UNIT, NO_UNIT);
		add_row("2", 1'b0, 1'b0, 2'd0, NO_UNIT, NO_UNIT);
		add_row("M", 1'b0, 1'b0, 2'd0, NO_UNIT, NO_UNIT);
		add_row("1", 1'b0, 1'b0, 2'd0, NO_UNIT, NO_UNIT);
		add_row("I", 1'b1, 1'b0, 2'd0, NO_UNIT, NO_UNIT);
		add_row("7", 1'b0, 1'b0, 2'd0, NO_UNIT, NO_UNIT);
		add_row(8'hFF, 1'b0, 1'b1, 2'd1, mk_unit(OP_M, 0, 1'b1, ERR_BAD_LETTER), NO_UNIT);
		add_row("5", 1'b0, 1'b0, 2'd0, NO_UNIT, NO_UNIT);
		add_row("M", 1'b1, 1'b0, 2'd0, NO_UNIT, NO_UNIT);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_char(directed_rows[i].ch, directed_rows[i].eos, directed_rows[i].typed,
				directed_rows[i].n, directed_rows[i].r0, directed_rows[i].r1);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			write_offset(offset_plan[p]);
			phase_start = chars_sent;
			while (chars_sent - phase_start < PHASE_CHARS)
				send_random_string();
		end

		settle();
		if (expected_units.size() != 0)
			report_mismatch($sformatf("%0d expected units never arrived",
				expected_units.size()));
		$display("tb: %0d characters sent, %0d units checked, %0d offset settings applied",
			chars_sent, units_checked, offset_writes);
		$display("tb: directed cases, random strings, broken strings, noise; %0d mismatches",
			mismatches);
		if (mismatches == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/csp_pkg.sv
rtl/csp_front.sv
rtl/csp_back.sv
rtl/cigar_string_parser_top.sv
rtl/csp_checker.sv
bench/tb.sv
